### hw/rtl/form_url_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// form url decoder assertion macros
// shared concurrent check forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef FORM_URL_DECODER_UNIT_ASSERT_SVH
`define FORM_URL_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define FUD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("form url decoder check failed");

// next-cycle implication
`define FUD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("form url decoder check failed");

`endif

### hw/rtl/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg
// character codes, result codes and helpers for the form url decoder
// ----------------------------------------------------------------------------
package fud_pkg;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   localparam int unsigned LEN_W = 14;
   localparam logic [LEN_W-1:0] KEEP_RESET = 14'd8192;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] DELIM_EQUALS = 2'd0;
   localparam logic [1:0] DELIM_AMP    = 2'd1;
   localparam logic [1:0] DELIM_EOI    = 2'd2;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_HIGH = 2'd1,
      PHASE_LOW  = 2'd2
   } phase_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            d = c - CHAR_LOWER_A + 8'd10;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            d = c - CHAR_UPPER_A + 8'd10;
         end
         nibble_of = d[3:0];
      end
   endfunction

endpackage

### hw/rtl/form_url_decoder_unit.sv
// ----------------------------------------------------------------------------
// form_url_decoder_unit
// form-encoded body decoder: splits items at '=' and '&', decodes '+' and
// percent escapes, limits kept bytes per item and reports every item end
// ----------------------------------------------------------------------------
// The block takes one body byte per clock cycle while the response side is
// ready. Each byte gives zero, one or two results (a decoded byte and/or an
// item end); they sit in a two-entry result register that hands out one per
// cycle, so a byte with two results holds the input while the second drains,
// and any other byte can be taken as its result leaves. The keep limit is
// written on the csr channel, always ready, and takes effect for later bytes.
// ----------------------------------------------------------------------------
`include "form_url_decoder_unit_assert.svh"

module form_url_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [13:0] csr_data,      // max_keep
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // in_byte
   input  logic        req_tlast,     // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // data_byte[7:0], delimiter[9:8], item_length[23:10]
   output logic        rsp_tuser,     // kind
   output logic        rsp_tlast      // last
);

   localparam int unsigned LW = fud_pkg::LEN_W;

   logic [LW-1:0]       max_keep_ff;
   fud_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]          high_ff, high_in;
   logic [LW-1:0]       kept_ff, kept_in;

   logic                data_v_ff, data_v_in;
   logic [7:0]          data_val_ff, data_val_in;
   logic                end_v_ff, end_v_in;
   logic [1:0]          end_delim_ff, end_delim_in;
   logic [LW-1:0]       end_len_ff, end_len_in;

   logic                req_xfer, rsp_xfer;
   logic [3:0]          nib;
   logic                d1, end1, d2, fin;
   logic [7:0]          val1, val2;
   logic [1:0]          delim1;
   fud_pkg::phase_type  ph_a;
   logic [3:0]          hi_a;
   logic                room1, room2, emit1, emit2;
   logic [LW-1:0]       k1, k2;

   assign csr_ready = 1'b1;
   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;
   assign req_tready = (!data_v_ff && !end_v_ff) || (rsp_tready && (data_v_ff ^ end_v_ff));

   always_comb begin
      nib    = fud_pkg::nibble_of(req_tdata);
      fin    = req_tlast;
      d1     = 1'b0;
      val1   = req_tdata;
      end1   = 1'b0;
      delim1 = fud_pkg::DELIM_EQUALS;
      ph_a   = phase_ff;
      hi_a   = high_ff;
      case (phase_ff)
         fud_pkg::PHASE_HIGH: begin
            hi_a = nib;
            ph_a = fud_pkg::PHASE_LOW;
         end
         fud_pkg::PHASE_LOW: begin
            d1   = 1'b1;
            val1 = {high_ff, nib};
            ph_a = fud_pkg::PHASE_IDLE;
            hi_a = 4'd0;
         end
         default: begin
            if (req_tdata == fud_pkg::CHAR_PERCENT) begin
               ph_a = fud_pkg::PHASE_HIGH;
               hi_a = 4'd0;
            end else if (req_tdata == fud_pkg::CHAR_EQUALS) begin
               end1   = 1'b1;
               delim1 = fud_pkg::DELIM_EQUALS;
            end else if (req_tdata == fud_pkg::CHAR_AMP) begin
               end1   = 1'b1;
               delim1 = fud_pkg::DELIM_AMP;
            end else if (req_tdata == fud_pkg::CHAR_PLUS) begin
               d1   = 1'b1;
               val1 = fud_pkg::CHAR_SPACE;
            end else begin
               d1 = 1'b1;
            end
         end
      endcase

      room1 = kept_ff < max_keep_ff;
      emit1 = d1 && room1;
      k1    = emit1 ? kept_ff + 14'd1 : kept_ff;

      // pending escape at end of body
      d2    = fin && (ph_a != fud_pkg::PHASE_IDLE);
      val2  = (ph_a == fud_pkg::PHASE_LOW) ? {hi_a, 4'd0} : 8'd0;
      room2 = k1 < max_keep_ff;
      emit2 = d2 && room2;
      k2    = emit2 ? k1 + 14'd1 : k1;

      if (fin || end1) begin
         kept_in = '0;
      end else begin
         kept_in = k2;
      end
      phase_in = fin ? fud_pkg::PHASE_IDLE : ph_a;
      high_in  = fin ? 4'd0 : hi_a;

      data_v_in    = emit1 || emit2;
      data_val_in  = emit1 ? val1 : val2;
      end_v_in     = end1 || fin;
      end_delim_in = end1 ? delim1 : fud_pkg::DELIM_EOI;
      end_len_in   = k2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_keep_ff <= fud_pkg::KEEP_RESET;
         phase_ff    <= fud_pkg::PHASE_IDLE;
         high_ff     <= 4'd0;
         kept_ff     <= '0;
         data_v_ff   <= 1'b0;
         end_v_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_keep_ff <= csr_data;
         end
         if (req_xfer) begin
            phase_ff  <= phase_in;
            high_ff   <= high_in;
            kept_ff   <= kept_in;
            data_v_ff <= data_v_in;
            end_v_ff  <= end_v_in;
         end else if (rsp_xfer) begin
            if (data_v_ff) begin
               data_v_ff <= 1'b0;
            end else begin
               end_v_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         data_val_ff  <= data_val_in;
         end_delim_ff <= end_delim_in;
         end_len_ff   <= end_len_in;
      end
   end

   assign rsp_tvalid = data_v_ff || end_v_ff;
   assign rsp_tuser  = data_v_ff ? fud_pkg::KIND_DATA : fud_pkg::KIND_END;
   assign rsp_tlast  = !(data_v_ff && end_v_ff);
   assign rsp_tdata  = data_v_ff ? {{LW{1'b0}}, 2'd0, data_val_ff}
                                 : {end_len_ff, end_delim_ff, 8'd0};

   // end of body returns the scan state to idle
   `FUD_ASSERT_NEXT(a_fin_clears, clock, reset, req_xfer && req_tlast,
      phase_ff == fud_pkg::PHASE_IDLE && high_ff == 4'd0 && kept_ff == '0)
   // a waiting decoded byte is never overwritten
   `FUD_ASSERT_NEXT(a_data_held, clock, reset, data_v_ff && !rsp_xfer, data_v_ff)
   // a delimiter outside an escape always produces an item end
   `FUD_ASSERT_NEXT(a_delim_end, clock, reset,
      req_xfer && phase_ff == fud_pkg::PHASE_IDLE &&
      (req_tdata == fud_pkg::CHAR_EQUALS || req_tdata == fud_pkg::CHAR_AMP),
      end_v_ff && !data_v_ff)

endmodule
